// ===== hw/rtl/fqa_pkg.sv =====
// fqa_pkg: types, constants and helper functions for the flow queue assigner.
// Used by fqa_cell, fqa_chain and flow_queue_assigner; depends on nothing.
package fqa_pkg;

    localparam int FLOW_ENTRIES = 64;
    localparam int NUM_QUEUES   = 8;
    localparam int FLOW_ID_BITS = 16;
    localparam int GATE_COUNT   = 8;

    localparam int FLOW_W      = 16;
    localparam int MASK_W      = 8;
    localparam int QUEUE_W     = 3;
    localparam int GATE_W      = 3;
    localparam int ROUTE_W     = 2;
    localparam int MAP_W       = GATE_COUNT * QUEUE_W;
    localparam int QCOUNT_W    = 4;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam int LFSR_W      = 16;
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = LFSR_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
    localparam logic [LFSR_W-1:0]   LFSR_SEED    = 16'hACE1;
    localparam logic [MAP_W-1:0]    MAP_RESET    = 24'hFAC688;
    localparam logic [QCOUNT_W-1:0] QUEUES_RESET = 4'd8;
    localparam logic [QCOUNT_W-1:0] QUEUES_MAX   = QCOUNT_W'(NUM_QUEUES);
    localparam logic [MASK_W-1:0]   QUEUE_MASK   = MASK_W'((1 << NUM_QUEUES) - 1);

    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_GATE    = 2'd0,
        ROUTE_CREDIT  = 2'd1,
        ROUTE_DEFAULT = 2'd2
    } route_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GATE_MAP      = 1'b0,
        REG_QUEUES_IN_USE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              is_credit;
        logic              is_bfc;
        logic [FLOW_W-1:0] flow_id;
        logic              last_packet;
        logic [MASK_W-1:0] queue_empty_mask;
    } item_t;

    typedef struct packed {
        route_t             route;
        logic [GATE_W-1:0]  gate_index;
        logic [QUEUE_W-1:0] queue_id;
        logic               table_hit;
        logic               table_full;
    } result_t;

    // lookup token walking the cell row
    typedef struct packed {
        logic                    vld;
        logic [FLOW_ID_BITS-1:0] flow;
        logic                    last;
        logic                    found;
        logic [QUEUE_W-1:0]      queue;
        logic                    free_found;
    } probe_t;

    // insert, taken by the cell that claimed the free slot
    typedef struct packed {
        logic                    en;
        logic [FLOW_ID_BITS-1:0] flow;
        logic [QUEUE_W-1:0]      queue;
    } commit_t;

    typedef struct packed {
        logic              hit;
        logic [GATE_W-1:0] idx;
    } gate_sel_t;

    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

    function automatic logic [QCOUNT_W-1:0] eff_queues(input logic [QCOUNT_W-1:0] q);
        logic [QCOUNT_W-1:0] e;
        e = q;
        if (q == '0)
        begin
            e = QCOUNT_W'(1);
        end
        else if (q > QUEUES_MAX)
        begin
            e = QUEUES_MAX;
        end
        return e;
    endfunction

    // remainder update over one digit, restoring style, one bit at a time
    function automatic logic [QUEUE_W-1:0] mod_digit(
        input logic [QUEUE_W-1:0]     rem,
        input logic [MOD_DIGIT_W-1:0] digit,
        input logic [QCOUNT_W-1:0]    modulus
    );
        logic [QCOUNT_W-1:0] t;
        logic [QUEUE_W-1:0]  r;
        r = rem;
        for (int b = MOD_DIGIT_W - 1; b >= 0; b--)
        begin
            t = {r, digit[b]};
            if (t >= modulus)
            begin
                t = t - modulus;
            end
            r = t[QUEUE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [QUEUE_W-1:0] lowest_empty(input logic [MASK_W-1:0] mask);
        logic [QUEUE_W-1:0] idx;
        idx = '0;
        for (int b = MASK_W - 1; b >= 0; b--)
        begin
            if (mask[b])
            begin
                idx = QUEUE_W'(b);
            end
        end
        return idx;
    endfunction

    function automatic gate_sel_t gate_lookup(
        input logic [MAP_W-1:0]   map,
        input logic [QUEUE_W-1:0] queue
    );
        gate_sel_t sel;
        sel = '0;
        for (int g = GATE_COUNT - 1; g >= 0; g--)
        begin
            if (map[QUEUE_W*g +: QUEUE_W] == queue)
            begin
                sel.hit = 1'b1;
                sel.idx = GATE_W'(g);
            end
        end
        return sel;
    endfunction

endpackage

// ===== hw/rtl/fqa_cell.sv =====
// fqa_cell: one flow table entry plus one stage of the lookup token path.
// Depends on fqa_pkg.
module fqa_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  fqa_pkg::probe_t  probe_in,
    input  logic             clear_claim,
    input  fqa_pkg::commit_t commit,
    output fqa_pkg::probe_t  probe_out
);

    logic                             valid_reg, valid_next;
    logic                             claim_reg, claim_next;
    logic                             probe_vld_reg;
    logic [fqa_pkg::FLOW_ID_BITS-1:0] flow_reg, flow_next;
    logic [fqa_pkg::QUEUE_W-1:0]      queue_reg, queue_next;
    fqa_pkg::probe_t                  probe_reg, probe_next;
    logic                             match;

    always_comb
    begin
        match      = valid_reg && (flow_reg == probe_in.flow);
        valid_next = valid_reg;
        flow_next  = flow_reg;
        queue_next = queue_reg;
        claim_next = clear_claim ? 1'b0 : claim_reg;
        probe_next = probe_in;
        if (probe_in.vld)
        begin
            if (match)
            begin
                probe_next.found = 1'b1;
                probe_next.queue = queue_reg;
                if (probe_in.last)
                begin
                    valid_next = 1'b0;
                end
            end
            if (!valid_reg && !probe_in.free_found)
            begin
                probe_next.free_found = 1'b1;
                claim_next            = 1'b1;
            end
        end
        if (commit.en && claim_reg)
        begin
            valid_next = 1'b1;
            flow_next  = commit.flow;
            queue_next = commit.queue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            claim_reg     <= 1'b0;
            probe_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            claim_reg     <= claim_next;
            probe_vld_reg <= probe_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg  <= flow_next;
        queue_reg <= queue_next;
        probe_reg <= probe_next;
    end

    always_comb
    begin
        probe_out     = probe_reg;
        probe_out.vld = probe_vld_reg;
    end

endmodule

// ===== hw/rtl/fqa_chain.sv =====
// fqa_chain: row of fqa_cell entries; the lookup token moves one cell per cycle.
// Depends on fqa_pkg and fqa_cell.
module fqa_chain (
    input  logic             clk,
    input  logic             rst_n,
    input  fqa_pkg::probe_t  probe_in,
    input  logic             clear_claim,
    input  fqa_pkg::commit_t commit,
    output fqa_pkg::probe_t  probe_out
);

    fqa_pkg::probe_t link [fqa_pkg::FLOW_ENTRIES+1];

    assign link[0] = probe_in;

    for (genvar i = 0; i < fqa_pkg::FLOW_ENTRIES; i++)
    begin : g_cell
        fqa_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .probe_in    (link[i]),
            .clear_claim (clear_claim),
            .commit      (commit),
            .probe_out   (link[i+1])
        );
    end

    assign probe_out = link[fqa_pkg::FLOW_ENTRIES];

endmodule

// ===== hw/rtl/flow_queue_assigner.sv =====
// flow_queue_assigner: top level; classifies items, runs the flow table lookup,
// picks and maps the queue. Depends on fqa_pkg and fqa_chain.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  input    | start / busy       | item   (fqa_pkg::item_t)
//  result   | done (1-cycle)     | result (fqa_pkg::result_t)
//  config   | cfg_write          | cfg_index, cfg_data
//
// Credit and non-BFC items: result strobed the next cycle.
// BFC items: the lookup token walks the cell row; when no queue is empty, the LFSR
// remainder is then worked out digit by digit in ST_MOD.
// Reset is asynchronous, active low; the table comes up empty, no clearing pass.
// done is a single-cycle strobe; the receiver cannot stall it.
module flow_queue_assigner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  fqa_pkg::item_t                     item,
    output logic                               busy,
    output logic                               done,
    output fqa_pkg::result_t                   result,
    input  logic                               cfg_write,
    input  logic [fqa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fqa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_MOD    = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [fqa_pkg::MAP_W-1:0]        gate_map_reg;
    logic [fqa_pkg::QCOUNT_W-1:0]     queues_reg;
    logic [fqa_pkg::LFSR_W-1:0]       lfsr_reg, lfsr_next_val;
    logic [fqa_pkg::FLOW_ID_BITS-1:0] flow_reg, flow_next;
    logic [fqa_pkg::MASK_W-1:0]       mask_reg, mask_next;
    logic [fqa_pkg::LFSR_W-1:0]       mod_val_reg, mod_val_next;
    logic [fqa_pkg::QUEUE_W-1:0]      mod_rem_reg, mod_rem_next;
    logic [fqa_pkg::MOD_CNT_W-1:0]    mod_cnt_reg, mod_cnt_next;
    logic                             done_reg, done_next;
    fqa_pkg::result_t                 result_reg, result_next;

    logic                             accept;
    logic [fqa_pkg::QCOUNT_W-1:0]     eff;
    logic [fqa_pkg::LFSR_W-1:0]       lfsr_adv;
    fqa_pkg::probe_t                  probe_in, chain_out;
    fqa_pkg::commit_t                 commit;
    logic                             fin_valid, fin_hit, fin_insert;
    logic [fqa_pkg::QUEUE_W-1:0]      fin_queue;
    fqa_pkg::gate_sel_t               gsel;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign eff      = fqa_pkg::eff_queues(queues_reg);
    assign lfsr_adv = fqa_pkg::lfsr_next(lfsr_reg);

    always_comb
    begin
        probe_in            = '0;
        probe_in.vld        = accept && item.is_bfc && !item.is_credit;
        probe_in.flow       = item.flow_id[fqa_pkg::FLOW_ID_BITS-1:0];
        probe_in.last       = item.last_packet;
    end

    fqa_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe_in    (probe_in),
        .clear_claim (probe_in.vld),
        .commit      (commit),
        .probe_out   (chain_out)
    );

    always_comb
    begin
        state_next    = state_reg;
        lfsr_next_val = lfsr_reg;
        flow_next     = flow_reg;
        mask_next     = mask_reg;
        mod_val_next  = mod_val_reg;
        mod_rem_next  = mod_rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        fin_valid     = 1'b0;
        fin_hit       = 1'b0;
        fin_insert    = 1'b0;
        fin_queue     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.is_credit)
                    begin
                        done_next         = 1'b1;
                        result_next       = '0;
                        result_next.route = fqa_pkg::ROUTE_CREDIT;
                    end
                    else if (!item.is_bfc)
                    begin
                        done_next         = 1'b1;
                        result_next       = '0;
                        result_next.route = fqa_pkg::ROUTE_DEFAULT;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                        flow_next  = item.flow_id[fqa_pkg::FLOW_ID_BITS-1:0];
                        mask_next  = item.queue_empty_mask & fqa_pkg::QUEUE_MASK;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (chain_out.vld)
                begin
                    if (chain_out.found)
                    begin
                        fin_valid  = 1'b1;
                        fin_hit    = 1'b1;
                        fin_queue  = chain_out.queue;
                        state_next = ST_IDLE;
                    end
                    else if (!chain_out.free_found)
                    begin
                        done_next              = 1'b1;
                        result_next            = '0;
                        result_next.route      = fqa_pkg::ROUTE_DEFAULT;
                        result_next.table_full = 1'b1;
                        state_next             = ST_IDLE;
                    end
                    else if (mask_reg != '0)
                    begin
                        fin_valid  = 1'b1;
                        fin_insert = 1'b1;
                        fin_queue  = fqa_pkg::lowest_empty(mask_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        lfsr_next_val = lfsr_adv;
                        mod_val_next  = lfsr_adv;
                        mod_rem_next  = '0;
                        mod_cnt_next  = '0;
                        state_next    = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                mod_rem_next = fqa_pkg::mod_digit(mod_rem_reg,
                    mod_val_reg[fqa_pkg::LFSR_W-1 -: fqa_pkg::MOD_DIGIT_W], eff);
                mod_val_next = mod_val_reg << fqa_pkg::MOD_DIGIT_W;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == fqa_pkg::MOD_CNT_W'(fqa_pkg::MOD_STEPS - 1))
                begin
                    fin_valid  = 1'b1;
                    fin_insert = 1'b1;
                    fin_queue  = mod_rem_next;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        gsel = fqa_pkg::gate_lookup(gate_map_reg, fin_queue);
        if (fin_valid)
        begin
            done_next              = 1'b1;
            result_next            = '0;
            result_next.route      = gsel.hit ? fqa_pkg::ROUTE_GATE : fqa_pkg::ROUTE_DEFAULT;
            result_next.gate_index = gsel.hit ? gsel.idx : '0;
            result_next.queue_id   = fin_queue;
            result_next.table_hit  = fin_hit;
        end

        commit       = '0;
        commit.en    = fin_insert;
        commit.flow  = flow_reg;
        commit.queue = fin_queue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gate_map_reg <= fqa_pkg::MAP_RESET;
            queues_reg   <= fqa_pkg::QUEUES_RESET;
            lfsr_reg     <= fqa_pkg::LFSR_SEED;
            mod_cnt_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lfsr_reg    <= lfsr_next_val;
            mod_cnt_reg <= mod_cnt_next;
            done_reg    <= done_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    fqa_pkg::REG_GATE_MAP:      gate_map_reg <= cfg_data[fqa_pkg::MAP_W-1:0];
                    fqa_pkg::REG_QUEUES_IN_USE: queues_reg   <= cfg_data[fqa_pkg::QCOUNT_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        flow_reg    <= flow_next;
        mask_reg    <= mask_next;
        mod_val_reg <= mod_val_next;
        mod_rem_reg <= mod_rem_next;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(result_reg.table_hit && result_reg.table_full))
        else $error("hit and full reported together");

    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.vld |-> (state_reg == ST_SEARCH))
        else $error("lookup token left the row outside search");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> ({1'b0, mod_rem_reg} < eff))
        else $error("remainder not below queue count");

    a_gate_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.route == fqa_pkg::ROUTE_GATE)) |->
        (gate_map_reg[fqa_pkg::QUEUE_W*result_reg.gate_index +: fqa_pkg::QUEUE_W]
            == result_reg.queue_id))
        else $error("gate does not serve the reported queue");

    a_search_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && (state_next == ST_IDLE)) |=> done_reg)
        else $error("item finished without a result strobe");

endmodule
